/* hdl/fa_clru_pkg.sv */
// Shared types and constants for the frame allocator with clean-page LRU replacement.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none

package fa_clru_pkg;

	// Fixed field widths of the request and result transfers.
	localparam int FRAME_W  = 6;
	localparam int SEG_W    = 6;
	localparam int STATUS_W = 3;
	localparam int TIME_W   = 32;

	// Default size of the frame pool.
	localparam int NUM_FRAMES_DEF = 64;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_FREE     = 3'd0,
		STAT_REPLACED = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_UPDATED  = 3'd3,
		STAT_UNUSED   = 3'd4
	} status_code_t;

	// Request kinds.
	localparam logic KIND_PLACE  = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_VICTIM,
		S_REPLACE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         capture;
		logic         scan_start;
		logic         scan_rd;
		logic         owner_rd;
		logic         fill_free;
		logic         fill_victim;
		logic         mark_dirty;
		logic         emit;
		status_code_t code;
	} fa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_update;
		logic free_avail;
		logic update_ok;
		logic scan_last;
		logic found;
	} fa_stat_t;

endpackage

`default_nettype wire

/* hdl/fa_clru_ctrl.sv */
// Controller state machine of the frame allocator: sequences dispatch, victim scan and replace.
// Depends on fa_clru_pkg for the state, command and status types.
`default_nettype none

module fa_clru_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire fa_clru_pkg::fa_stat_t stat,
	output fa_clru_pkg::fa_cmd_t     cmd,
	output logic                     busy
);
	import fa_clru_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.code  = STAT_FREE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_update) begin
					// An update either refreshes a frame in use or reports it unused.
					cmd.mark_dirty = stat.update_ok;
					cmd.emit       = 1'b1;
					cmd.code       = stat.update_ok ? STAT_UPDATED : STAT_UNUSED;
					state_nxt      = S_IDLE;
				end else if (stat.free_avail) begin
					cmd.fill_free = 1'b1;
					cmd.emit      = 1'b1;
					cmd.code      = STAT_FREE;
					state_nxt     = S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				// One frame read per cycle from the use-time memory.
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last read datum is compared in this cycle.
				state_nxt = S_VICTIM;
			end
			S_VICTIM: begin
				if (stat.found) begin
					cmd.owner_rd = 1'b1;
					state_nxt    = S_REPLACE;
				end else begin
					cmd.emit  = 1'b1;
					cmd.code  = STAT_FULL;
					state_nxt = S_IDLE;
				end
			end
			S_REPLACE: begin
				cmd.fill_victim = 1'b1;
				cmd.emit        = 1'b1;
				cmd.code        = STAT_REPLACED;
				state_nxt       = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/fa_clru_dp.sv */
// Datapath of the frame allocator: request and result registers, counters, frame memories
// and the LRU compare. Depends on fa_clru_pkg for widths, codes and the command/status types.
`default_nettype none

module fa_clru_dp #(
	parameter int NUM_FRAMES = fa_clru_pkg::NUM_FRAMES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fa_clru_pkg::fa_cmd_t              cmd,
	output fa_clru_pkg::fa_stat_t                  stat,
	input  wire logic                              kind,
	input  wire logic [fa_clru_pkg::SEG_W-1:0]     segment,
	input  wire logic [fa_clru_pkg::FRAME_W-1:0]   frame,
	input  wire logic                              place_dirty,
	output logic                                   done,
	output logic [fa_clru_pkg::STATUS_W-1:0]       status,
	output logic [fa_clru_pkg::FRAME_W-1:0]        frame_out,
	output logic                                   evicted_valid,
	output logic [fa_clru_pkg::SEG_W-1:0]          evicted_segment
);
	import fa_clru_pkg::*;

	localparam int AW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int NUW   = $clog2(NUM_FRAMES + 1);
	localparam int CMP_W = (NUW > FRAME_W) ? NUW : FRAME_W;
	localparam int META_W = TIME_W + 1;

	// Captured request.
	logic              kind_q;
	logic [SEG_W-1:0]  seg_q;
	logic [FRAME_W-1:0] frame_q;
	logic              dirty_q;
	logic [TIME_W-1:0] now_q;

	// Allocation and event counters.
	logic [NUW-1:0]    next_unused_q;
	logic [TIME_W-1:0] use_clock_q;

	// Victim scan state.
	logic [AW-1:0]     scan_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic [META_W-1:0] meta_rd_s1;
	logic              found_q;
	logic [AW-1:0]     best_q;
	logic [TIME_W-1:0] best_time_q;
	logic [SEG_W-1:0]  owner_rd_q;

	// Frame memories: {modified, last use time} and owner segment.
	logic [META_W-1:0] meta_mem [NUM_FRAMES];
	logic [SEG_W-1:0]  owner_mem [NUM_FRAMES];

	// Write port controls.
	logic              meta_we;
	logic [AW-1:0]     meta_waddr;
	logic [META_W-1:0] meta_wdata;
	logic              owner_we;
	logic [AW-1:0]     fill_addr;
	logic              cand_better;

	// Result registers.
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [FRAME_W-1:0]  frame_out_q;
	logic                ev_valid_q;
	logic [SEG_W-1:0]    ev_seg_q;

	// Status toward the controller.
	assign stat.is_update  = (kind_q == KIND_UPDATE);
	assign stat.free_avail = (next_unused_q < NUW'(NUM_FRAMES));
	assign stat.update_ok  = (CMP_W'(frame_q) < CMP_W'(next_unused_q));
	assign stat.scan_last  = (scan_q == AW'(NUM_FRAMES - 1));
	assign stat.found      = found_q;

	// Request capture; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			seg_q   <= segment;
			frame_q <= frame;
			dirty_q <= place_dirty;
			now_q   <= use_clock_q;
		end
	end

	// Counters: use clock advances on every transfer, next_unused on a free placement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_clock_q   <= '0;
			next_unused_q <= '0;
		end else begin
			if (cmd.capture) begin
				use_clock_q <= use_clock_q + 1'b1;
			end
			if (cmd.fill_free) begin
				next_unused_q <= next_unused_q + 1'b1;
			end
		end
	end

	// Memory write selection: fills write both memories, updates write only the meta word.
	assign fill_addr = cmd.fill_free ? next_unused_q[AW-1:0] : best_q;
	always_comb begin
		meta_we    = cmd.fill_free | cmd.fill_victim | cmd.mark_dirty;
		owner_we   = cmd.fill_free | cmd.fill_victim;
		meta_waddr = fill_addr;
		meta_wdata = {dirty_q, now_q};
		if (cmd.mark_dirty) begin
			meta_waddr = AW'(frame_q);
			meta_wdata = {1'b1, now_q};
		end
	end

	// Frame memories with registered reads.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rd_s1 <= meta_mem[scan_q];
	end

	always_ff @(posedge clk) begin
		if (owner_we) begin
			owner_mem[fill_addr] <= seg_q;
		end
		if (cmd.owner_rd) begin
			owner_rd_q <= owner_mem[best_q];
		end
	end

	// A clean frame wins if it is the first found or strictly older than the candidate.
	assign cand_better = !meta_rd_s1[META_W-1] &&
		(!found_q || (meta_rd_s1[TIME_W-1:0] < best_time_q));

	// Scan address, read pipeline and victim tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_start) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_q <= scan_q + 1'b1;
				end
				if (rd_vld_s1 && cand_better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= scan_q;
		if (rd_vld_s1 && cand_better) begin
			best_q      <= rd_addr_s1;
			best_time_q <= meta_rd_s1[TIME_W-1:0];
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// Result payload, loaded when a result is issued.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.code;
			case (cmd.code)
				STAT_FREE: begin
					frame_out_q <= FRAME_W'(next_unused_q);
					ev_valid_q  <= 1'b0;
					ev_seg_q    <= '0;
				end
				STAT_REPLACED: begin
					frame_out_q <= FRAME_W'(best_q);
					ev_valid_q  <= 1'b1;
					ev_seg_q    <= owner_rd_q;
				end
				STAT_UPDATED, STAT_UNUSED: begin
					frame_out_q <= frame_q;
					ev_valid_q  <= 1'b0;
					ev_seg_q    <= '0;
				end
				default: begin
					frame_out_q <= '0;
					ev_valid_q  <= 1'b0;
					ev_seg_q    <= '0;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign frame_out       = frame_out_q;
	assign evicted_valid   = ev_valid_q;
	assign evicted_segment = ev_seg_q;

endmodule

`default_nettype wire

/* hdl/frame_allocator_clean_lru_unit.sv */
// Top level of the page frame allocator with LRU replacement of clean pages.
// Instantiates fa_clru_ctrl and fa_clru_dp; depends on fa_clru_pkg.
//
// Channel    Direction  Handshake                 Payload
// request    in         start, busy               kind, segment, frame, place_dirty
// result     out        done (one-cycle strobe)   status, frame_out, evicted_valid,
//                                                 evicted_segment
//
// A request transfer happens at a rising edge with start high and busy low.
// An update or a placement into a never-used frame keeps busy high for one cycle.
// Busy drops at the same edge at which the result strobe rises.
// A replacement scans the use-time memory one frame per cycle through its single
// read port, then steps through drain, victim and replace; the strobe rises as busy drops.
// Memory full skips the replace state and drops busy from the victim state.
// Reset clears the counters and the controller; the memories need no clearing pass.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module frame_allocator_clean_lru_unit #(
	parameter int NUM_FRAMES = fa_clru_pkg::NUM_FRAMES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              kind,
	input  wire logic [fa_clru_pkg::SEG_W-1:0]     segment,
	input  wire logic [fa_clru_pkg::FRAME_W-1:0]   frame,
	input  wire logic                              place_dirty,
	output logic                                   done,
	output logic [fa_clru_pkg::STATUS_W-1:0]       status,
	output logic [fa_clru_pkg::FRAME_W-1:0]        frame_out,
	output logic                                   evicted_valid,
	output logic [fa_clru_pkg::SEG_W-1:0]          evicted_segment
);
	import fa_clru_pkg::*;

	fa_cmd_t  cmd;
	fa_stat_t stat;

	// Controller.
	fa_clru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	fa_clru_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.segment         (segment),
		.frame           (frame),
		.place_dirty     (place_dirty),
		.done            (done),
		.status          (status),
		.frame_out       (frame_out),
		.evicted_valid   (evicted_valid),
		.evicted_segment (evicted_segment)
	);

	// Every result follows a cycle in which a request was being worked on.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result strobe without a request in progress.");

	// A transfer always makes the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Request transfer did not make the block busy.");

	// Memory full is never reported while never-used frames remain.
	a_full_only_without_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_FULL)) |-> !stat.free_avail)
		else $error("Memory full reported with unused frames left.");

	// A result flags the evicted segment as valid exactly when it is a replacement.
	a_replace_evicts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (evicted_valid == (status == STAT_REPLACED)))
		else $error("Eviction flag does not match the result status.");

endmodule

`default_nettype wire

/* tb/tb_frame_allocator_clean_lru_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for frame_allocator_clean_lru_unit: directed head, random requests, directed tail.
// Results are compared against an in-bench allocator model; depends on fa_clru_pkg and the RTL.

module tb_frame_allocator_clean_lru_unit;
	import fa_clru_pkg::*;

	localparam int FRAMES      = NUM_FRAMES_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int CLEAN_FLOOR = 16;
	localparam int PRINT_CAP   = 200;

	// One result transfer as the block reports it.
	typedef struct packed {
		status_code_t               st;
		logic [FRAME_W-1:0]         fr;
		logic                       ev;
		logic [SEG_W-1:0]           seg;
	} alloc_result_t;

	// One row of the directed stimulus; repeated rows step segment and frame by one.
	typedef struct {
		logic               k;
		logic [SEG_W-1:0]   seg;
		logic [FRAME_W-1:0] fr;
		logic               d;
		int                 reps;
		bit                 typed;
		alloc_result_t      res;
	} stim_row_t;

	localparam alloc_result_t NO_RES = '0;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               kind = KIND_PLACE;
	logic [SEG_W-1:0]   segment = '0;
	logic [FRAME_W-1:0] frame = '0;
	logic               place_dirty = 1'b0;
	logic               done;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0] frame_out;
	logic               evicted_valid;
	logic [SEG_W-1:0]   evicted_segment;

	// Allocator state mirrored by the bench.
	bit [6:0]           free_next;
	bit                 held [FRAMES];
	bit                 modified [FRAMES];
	bit [SEG_W-1:0]     owner_of [FRAMES];
	bit [TIME_W-1:0]    last_touch [FRAMES];
	bit [TIME_W-1:0]    event_count;

	alloc_result_t      pending_results [$];
	stim_row_t          plan [$];
	int                 mismatch_count = 0;
	int                 requests_sent = 0;
	int                 cycle_count = 0;
	int                 status_seen [5] = '{default: 0};
	bit                 no_gaps = 1'b0;

	frame_allocator_clean_lru_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.segment         (segment),
		.frame           (frame),
		.place_dirty     (place_dirty),
		.done            (done),
		.status          (status),
		.frame_out       (frame_out),
		.evicted_valid   (evicted_valid),
		.evicted_segment (evicted_segment)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("frame_allocator_clean_lru_unit test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Works out the result of one request and updates the mirrored state.
	task automatic predict_alloc(input logic k, input logic [SEG_W-1:0] seg,
			input logic [FRAME_W-1:0] fr, input logic d, output alloc_result_t r);
		bit [TIME_W-1:0] now;
		bit hit;
		int victim;
		now = event_count;
		event_count = event_count + 1;
		r = '{STAT_FULL, '0, 1'b0, '0};
		hit = 1'b0;
		victim = 0;
		if (k == KIND_PLACE) begin
			if (free_next < FRAMES) begin
				victim = free_next;
				free_next++;
				hit = 1'b1;
				r = '{STAT_FREE, FRAME_W'(victim), 1'b0, '0};
			end else begin
				// Oldest clean page wins; the lowest frame keeps a tie.
				for (int i = 0; i < FRAMES; i++) begin
					if (held[i] && !modified[i] && (!hit || last_touch[i] < last_touch[victim])) begin
						victim = i;
						hit = 1'b1;
					end
				end
				if (hit)
					r = '{STAT_REPLACED, FRAME_W'(victim), 1'b1, owner_of[victim]};
			end
			if (hit) begin
				held[victim] = 1'b1;
				modified[victim] = d;
				owner_of[victim] = seg;
				last_touch[victim] = now;
			end
		end else if (held[fr]) begin
			modified[fr] = 1'b1;
			last_touch[fr] = now;
			r = '{STAT_UPDATED, fr, 1'b0, '0};
		end else begin
			r = '{STAT_UNUSED, fr, 1'b0, '0};
		end
	endtask

	function automatic int clean_frames();
		int n;
		n = 0;
		for (int i = 0; i < FRAMES; i++)
			if (held[i] && !modified[i])
				n++;
		return n;
	endfunction

	// Drives one request until its transfer, then queues what it should produce.
	task automatic issue_request(input logic k, input logic [SEG_W-1:0] seg,
			input logic [FRAME_W-1:0] fr, input logic d, input bit typed,
			input alloc_result_t typed_res);
		alloc_result_t r;
		while (!no_gaps && $urandom_range(99) < 25) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		segment <= seg;
		frame <= fr;
		place_dirty <= d;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_alloc(k, seg, fr, d, r);
		pending_results.push_back(typed ? typed_res : r);
		requests_sent++;
	endtask

	task automatic add_row(input logic k, input logic [SEG_W-1:0] seg,
			input logic [FRAME_W-1:0] fr, input logic d, input int reps,
			input bit typed, input alloc_result_t res);
		stim_row_t row;
		row = '{k, seg, fr, d, reps, typed, res};
		plan.push_back(row);
	endtask

	task automatic run_plan();
		foreach (plan[r])
			for (int i = 0; i < plan[r].reps; i++)
				issue_request(plan[r].k, SEG_W'(plan[r].seg + i), FRAME_W'(plan[r].fr + i),
					plan[r].d, plan[r].typed, plan[r].res);
		plan.delete();
	endtask

	// Sender holds off until every outstanding result has been seen.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Result checker: each strobe is a transfer and is matched with the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && done === 1'b1) begin
			if (status < 5)
				status_seen[status]++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (frame_out !== want.fr)
					report_mismatch($sformatf("frame_out %0d, expected %0d", frame_out, want.fr));
				if (evicted_valid !== want.ev)
					report_mismatch($sformatf("evicted_valid %0b, expected %0b",
						evicted_valid, want.ev));
				if (evicted_segment !== want.seg)
					report_mismatch($sformatf("evicted_segment %0d, expected %0d",
						evicted_segment, want.seg));
			end
		end
	end

	initial begin : stimulus
		logic               k;
		logic               d;
		logic [SEG_W-1:0]   seg;
		logic [FRAME_W-1:0] fr;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed head: empty pool, first free frames, fill, first replacements.
		add_row(KIND_UPDATE, 6'd0,  6'd0,  1'b0, 1,  1'b1, '{STAT_UNUSED, 6'd0, 1'b0, 6'd0});
		add_row(KIND_UPDATE, 6'd63, 6'd63, 1'b1, 1,  1'b1, '{STAT_UNUSED, 6'd63, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd0,  6'd0,  1'b0, 1,  1'b1, '{STAT_FREE, 6'd0, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd63, 6'd63, 1'b1, 1,  1'b1, '{STAT_FREE, 6'd1, 1'b0, 6'd0});
		add_row(KIND_UPDATE, 6'd5,  6'd1,  1'b0, 1,  1'b1, '{STAT_UPDATED, 6'd1, 1'b0, 6'd0});
		add_row(KIND_UPDATE, 6'd0,  6'd2,  1'b1, 1,  1'b1, '{STAT_UNUSED, 6'd2, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd10, 6'd0,  1'b0, 62, 1'b0, NO_RES);
		add_row(KIND_UPDATE, 6'd0,  6'd3,  1'b0, 1,  1'b1, '{STAT_UPDATED, 6'd3, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd33, 6'd0,  1'b1, 1,  1'b0, NO_RES);
		add_row(KIND_PLACE,  6'd0,  6'd63, 1'b0, 1,  1'b0, NO_RES);
		add_row(KIND_PLACE,  6'd63, 6'd0,  1'b0, 1,  1'b0, NO_RES);
		add_row(KIND_UPDATE, 6'd63, 6'd63, 1'b0, 1,  1'b1, '{STAT_UPDATED, 6'd63, 1'b0, 6'd0});
		add_row(KIND_UPDATE, 6'd0,  6'd4,  1'b1, 1,  1'b1, '{STAT_UPDATED, 6'd4, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd21, 6'd0,  1'b0, 3,  1'b0, NO_RES);
		add_row(KIND_UPDATE, 6'd0,  6'd0,  1'b0, 1,  1'b1, '{STAT_UPDATED, 6'd0, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd42, 6'd0,  1'b1, 1,  1'b0, NO_RES);
		run_plan();
		drain_results();

		// Random traffic that keeps a pool of clean pages so replacements keep happening.
		for (int n = 0; n < 600; n++) begin
			no_gaps = (n >= 250 && n < 400);
			k = ($urandom_range(99) < 35) ? KIND_UPDATE : KIND_PLACE;
			seg = SEG_W'($urandom);
			fr = FRAME_W'($urandom);
			d = ($urandom_range(3) == 0);
			if (clean_frames() <= CLEAN_FLOOR) begin
				// Only refresh pages that are already dirty; new pages stay clean.
				d = 1'b0;
				for (int j = 0; j < FRAMES && !modified[fr]; j++)
					fr = fr + 1'b1;
			end
			issue_request(k, seg, fr, d, 1'b0, NO_RES);
		end
		no_gaps = 1'b0;
		drain_results();

		// Random traffic that dirties the pool until it runs full.
		for (int n = 0; n < 100; n++) begin
			k = $urandom_range(1) ? KIND_UPDATE : KIND_PLACE;
			issue_request(k, SEG_W'($urandom), FRAME_W'($urandom), 1'b1, 1'b0, NO_RES);
		end

		// Directed tail: every frame dirty, then memory full.
		add_row(KIND_UPDATE, 6'd0,  6'd0,  1'b0, 64, 1'b0, NO_RES);
		add_row(KIND_PLACE,  6'd0,  6'd0,  1'b0, 1,  1'b1, '{STAT_FULL, 6'd0, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd63, 6'd63, 1'b1, 1,  1'b1, '{STAT_FULL, 6'd0, 1'b0, 6'd0});
		add_row(KIND_UPDATE, 6'd9,  6'd5,  1'b0, 1,  1'b1, '{STAT_UPDATED, 6'd5, 1'b0, 6'd0});
		add_row(KIND_PLACE,  6'd17, 6'd40, 1'b0, 1,  1'b1, '{STAT_FULL, 6'd0, 1'b0, 6'd0});
		run_plan();
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * FRAMES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("Covered %0d requests: %0d free-frame, %0d replacement, %0d full results,",
			requests_sent, status_seen[STAT_FREE], status_seen[STAT_REPLACED],
			status_seen[STAT_FULL]);
		$display("%0d updates and %0d updates of unused frames; %0d mismatches.",
			status_seen[STAT_UPDATED], status_seen[STAT_UNUSED], mismatch_count);
		if (mismatch_count == 0)
			$display("frame_allocator_clean_lru_unit test passed");
		else
			$display("frame_allocator_clean_lru_unit test failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/fa_clru_pkg.sv
hdl/fa_clru_ctrl.sv
hdl/fa_clru_dp.sv
hdl/frame_allocator_clean_lru_unit.sv
tb/tb_frame_allocator_clean_lru_unit.sv
